### src/mtep_pkg.sv
// mtep_pkg: shared types and constants for the midi track event parser
// no dependencies; used by every module in src
package mtep_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHANNEL   = 2'd0,
    KIND_TEMPO     = 2'd1,
    KIND_END_CLEAN = 2'd2,
    KIND_END_TRUNC = 2'd3
  } kind_e;

  // parser phases
  typedef enum logic [3:0] {
    PH_DELTA      = 4'd0,
    PH_STATUS     = 4'd1,
    PH_META_TYPE  = 4'd2,
    PH_META_LEN   = 4'd3,
    PH_META_DATA  = 4'd4,
    PH_TEMPO_DATA = 4'd5,
    PH_SYSEX_LEN  = 4'd6,
    PH_SYSEX_DATA = 4'd7,
    PH_CH_D1      = 4'd8,
    PH_CH_D2      = 4'd9
  } phase_e;

  localparam logic [7:0] StatusMeta     = 8'hFF;
  localparam logic [7:0] StatusSysex    = 8'hF0;
  localparam logic [7:0] StatusSysexEsc = 8'hF7;
  localparam logic [7:0] MetaTempo      = 8'h51;
  localparam logic [3:0] HiNoteOff      = 4'h8;
  localparam logic [3:0] HiNoteOn       = 4'h9;
  localparam logic [3:0] HiCtrlChange   = 4'hB;
  localparam logic [3:0] HiProgChange   = 4'hC;
  localparam logic [3:0] HiChanPress    = 4'hD;
  localparam logic [31:0] TempoLen      = 32'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_end;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] tick;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [23:0] tempo_micros;
    logic [31:0] event_index;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    phase_e      phase;
    logic [63:0] absolute_tick;
    logic [7:0]  running_status;
    logic [31:0] varlen_accum;
    logic [7:0]  meta_kind;
    logic [31:0] bytes_remaining;
    logic [7:0]  held_first_data;
    logic [23:0] tempo_accum;
    logic [31:0] event_counter;
  } parser_state_t;

  // request from the parser to the result buffer
  typedef struct packed {
    logic load;
    logic pair;
  } res_ctl_t;

endpackage

### src/mtep_step.sv
// mtep_step: next-state and result decode for one track byte
// depends on mtep_pkg
module mtep_step (
  input  mtep_pkg::parser_state_t state_i,
  input  mtep_pkg::in_beat_t      beat_i,
  output mtep_pkg::parser_state_t state_o,
  output mtep_pkg::out_beat_t     res0_o,
  output mtep_pkg::out_beat_t     res1_o,
  output logic [1:0]              count_o
);

  mtep_pkg::parser_state_t nxt;
  mtep_pkg::phase_e        ph;
  mtep_pkg::phase_e        entry_ph;
  mtep_pkg::out_beat_t     ev;
  mtep_pkg::out_beat_t     fin;
  logic [7:0]              b;
  logic [31:0]             cur_varlen;
  logic [31:0]             shifted;
  logic [31:0]             rem_dec;
  logic [23:0]             tempo_new;
  logic [3:0]              hi;
  logic [63:0]             add_val;
  logic [63:0]             sum_tick;
  logic                    ev_valid;
  logic                    delta_done;
  logic                    clean;

  assign b  = beat_i.data_byte;
  assign hi = state_i.running_status[7:4];

  always_comb begin
    priority if (state_i.running_status == mtep_pkg::StatusMeta) begin
      entry_ph = mtep_pkg::PH_META_TYPE;
    end else if (state_i.running_status == mtep_pkg::StatusSysex ||
                 state_i.running_status == mtep_pkg::StatusSysexEsc) begin
      entry_ph = mtep_pkg::PH_SYSEX_LEN;
    end else begin
      entry_ph = mtep_pkg::PH_CH_D1;
    end
  end

  // byte consumption
  always_comb begin
    nxt        = state_i;
    ev         = '0;
    ev_valid   = 1'b0;
    delta_done = 1'b0;
    ph         = state_i.phase;
    cur_varlen = state_i.varlen_accum;
    // data byte where a status was expected falls back on running status
    if (state_i.phase == mtep_pkg::PH_STATUS && !b[7]) begin
      ph         = entry_ph;
      cur_varlen = '0;
    end
    shifted          = {cur_varlen[24:0], b[6:0]};
    rem_dec          = state_i.bytes_remaining - 32'd1;
    tempo_new        = {state_i.tempo_accum[15:0], b};
    nxt.varlen_accum = cur_varlen;

    ev.tick        = state_i.absolute_tick;
    ev.event_index = state_i.event_counter;

    unique case (ph)
      mtep_pkg::PH_STATUS: begin
        nxt.running_status = b;
        nxt.varlen_accum   = '0;
        priority if (b == mtep_pkg::StatusMeta) begin
          nxt.phase = mtep_pkg::PH_META_TYPE;
        end else if (b == mtep_pkg::StatusSysex || b == mtep_pkg::StatusSysexEsc) begin
          nxt.phase = mtep_pkg::PH_SYSEX_LEN;
        end else begin
          nxt.phase = mtep_pkg::PH_CH_D1;
        end
      end
      mtep_pkg::PH_META_TYPE: begin
        nxt.meta_kind    = b;
        nxt.varlen_accum = '0;
        nxt.phase        = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
        nxt.varlen_accum = shifted;
        nxt.phase        = ph;
        if (!b[7]) begin
          nxt.bytes_remaining = shifted;
          nxt.varlen_accum    = '0;
          priority if (shifted == '0) begin
            nxt.phase = mtep_pkg::PH_DELTA;
          end else if (ph == mtep_pkg::PH_META_LEN &&
                       state_i.meta_kind == mtep_pkg::MetaTempo &&
                       shifted == mtep_pkg::TempoLen) begin
            nxt.tempo_accum = '0;
            nxt.phase       = mtep_pkg::PH_TEMPO_DATA;
          end else if (ph == mtep_pkg::PH_META_LEN) begin
            nxt.phase = mtep_pkg::PH_META_DATA;
          end else begin
            nxt.phase = mtep_pkg::PH_SYSEX_DATA;
          end
        end
      end
      mtep_pkg::PH_META_DATA, mtep_pkg::PH_SYSEX_DATA: begin
        nxt.bytes_remaining = rem_dec;
        nxt.phase           = (rem_dec == '0) ? mtep_pkg::PH_DELTA : ph;
      end
      mtep_pkg::PH_TEMPO_DATA: begin
        nxt.tempo_accum     = tempo_new;
        nxt.bytes_remaining = rem_dec;
        // a count that wrapped below zero also ends the event
        if (rem_dec == '0 || rem_dec > mtep_pkg::TempoLen) begin
          ev_valid            = 1'b1;
          ev.kind             = mtep_pkg::KIND_TEMPO;
          ev.tempo_micros     = tempo_new;
          nxt.bytes_remaining = '0;
          nxt.phase           = mtep_pkg::PH_DELTA;
        end else begin
          nxt.phase = mtep_pkg::PH_TEMPO_DATA;
        end
      end
      mtep_pkg::PH_CH_D1: begin
        if (hi == mtep_pkg::HiProgChange || hi == mtep_pkg::HiChanPress) begin
          nxt.phase = mtep_pkg::PH_DELTA;
        end else begin
          nxt.held_first_data = b;
          nxt.phase           = mtep_pkg::PH_CH_D2;
        end
      end
      mtep_pkg::PH_CH_D2: begin
        if (hi == mtep_pkg::HiNoteOn || hi == mtep_pkg::HiNoteOff ||
            hi == mtep_pkg::HiCtrlChange) begin
          ev_valid       = 1'b1;
          ev.kind        = mtep_pkg::KIND_CHANNEL;
          ev.status_byte = state_i.running_status;
          ev.first_data  = state_i.held_first_data;
          ev.second_data = b;
        end
        nxt.phase = mtep_pkg::PH_DELTA;
      end
      default: begin
        // delta time, and any phase code with no meaning
        nxt.varlen_accum = shifted;
        nxt.phase        = mtep_pkg::PH_DELTA;
        if (!b[7]) begin
          delta_done       = 1'b1;
          nxt.varlen_accum = '0;
          nxt.phase        = mtep_pkg::PH_STATUS;
        end
      end
    endcase
  end

  // one shared adder: finished delta, or the partial delta at track end
  always_comb begin
    priority if (delta_done) begin
      add_val = {32'd0, shifted};
    end else if (beat_i.track_end && nxt.phase == mtep_pkg::PH_DELTA) begin
      add_val = {32'd0, nxt.varlen_accum};
    end else begin
      add_val = '0;
    end
  end
  assign sum_tick = state_i.absolute_tick + add_val;

  always_comb begin
    unique case (nxt.phase)
      mtep_pkg::PH_DELTA, mtep_pkg::PH_STATUS: clean = 1'b1;
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: clean = (nxt.varlen_accum == '0);
      default: clean = 1'b0;
    endcase
  end

  always_comb begin
    fin             = '0;
    fin.kind        = clean ? mtep_pkg::KIND_END_CLEAN : mtep_pkg::KIND_END_TRUNC;
    fin.tick        = sum_tick;
    fin.last_of_run = 1'b1;
  end

  always_comb begin
    state_o               = nxt;
    state_o.absolute_tick = delta_done ? sum_tick : state_i.absolute_tick;
    state_o.event_counter = state_i.event_counter + {31'd0, ev_valid};
    res0_o                = ev;
    res1_o                = fin;
    count_o               = 2'd0;
    if (beat_i.track_end) begin
      state_o                 = '0;
      state_o.phase           = mtep_pkg::PH_DELTA;
      state_o.event_counter   = state_i.event_counter + {31'd0, ev_valid};
    end
    unique case ({ev_valid, beat_i.track_end})
      2'b11: count_o = 2'd2;
      2'b10: begin
        count_o            = 2'd1;
        res0_o.last_of_run = 1'b1;
      end
      2'b01: begin
        count_o = 2'd1;
        res0_o  = fin;
      end
      default: count_o = 2'd0;
    endcase
  end

endmodule

### src/mtep_res_buf.sv
// mtep_res_buf: two-slot result register feeding the output channel
// depends on mtep_pkg
module mtep_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtep_pkg::res_ctl_t  ctl_i,
  input  mtep_pkg::out_beat_t res0_i,
  input  mtep_pkg::out_beat_t res1_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtep_pkg::out_beat_t out_data_o
);

  logic [1:0]          cnt_q, cnt_d;
  mtep_pkg::out_beat_t slot0_q, slot0_d;
  mtep_pkg::out_beat_t slot1_q, slot1_d;
  logic                take;

  assign take        = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (ctl_i.load) begin
      slot0_d = res0_i;
      slot1_d = res1_i;
      cnt_d   = ctl_i.pair ? 2'd2 : 2'd1;
    end else if (take) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

### src/midi_track_event_parser.sv
// midi_track_event_parser: top level, input register, parser state, result buffer
// depends on mtep_pkg, mtep_step, mtep_res_buf
//
//   channel | signals                          | beat
//   in      | in_valid_i, in_ready_o, in_data_i  | one track byte plus end flag
//   out     | out_valid_o, out_ready_i, out_data_o | one parsed event or end report
//
// a byte is decoded in the cycle after it is accepted; its first beat is registered
// into the result buffer when the byte is consumed
// one byte per cycle while the output keeps up; a byte giving two results holds the
// next result-giving byte, since the result buffer drains one beat per cycle
// bytes that give no result pass even while the output is stalled
// reset clears the parser state and the event counter; no clearing pass
module midi_track_event_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mtep_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtep_pkg::out_beat_t out_data_o
);

  logic                    in_valid_q;
  mtep_pkg::in_beat_t      in_q;
  mtep_pkg::parser_state_t state_q, state_d;
  mtep_pkg::out_beat_t     res0, res1;
  mtep_pkg::res_ctl_t      ctl;
  logic [1:0]              count;
  logic                    can_load;
  logic                    consume;

  mtep_step u_step (
    .state_i (state_q),
    .beat_i  (in_q),
    .state_o (state_d),
    .res0_o  (res0),
    .res1_o  (res1),
    .count_o (count)
  );

  assign consume    = in_valid_q && ((count == 2'd0) || can_load);
  assign ctl.load   = consume && (count != 2'd0);
  assign ctl.pair   = (count == 2'd2);
  assign in_ready_o = !in_valid_q || consume;

  mtep_res_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .res0_i      (res0),
    .res1_i      (res1),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (consume) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  a_empty_buf_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> can_load)
    else $error("empty result buffer refuses a load");

  a_counter_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !consume |=> $stable(state_q.event_counter))
    else $error("event counter moved without a consumed byte");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_q.track_end |=>
      state_q.phase == mtep_pkg::PH_DELTA && state_q.absolute_tick == '0)
    else $error("parser not cleared after track end");

  a_pair_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load && ctl.pair |-> in_q.track_end)
    else $error("two results from a byte without track end");

endmodule
